[rtl/core/bmsp_pkg.sv]
package bmsp_pkg;

  typedef enum logic [2:0] {
    KIND_INSTR      = 3'd0,
    KIND_LABEL_BYTE = 3'd1,
    KIND_LABEL_END  = 3'd2,
    KIND_DONE       = 3'd3,
    KIND_ERROR      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ERR_UNMATCHED = 2'd0,
    ERR_UNCLOSED  = 2'd1,
    ERR_DEPTH     = 2'd2,
    ERR_LONG      = 2'd3
  } err_t;

  localparam logic [2:0] OP_LEFT  = 3'd0;
  localparam logic [2:0] OP_RIGHT = 3'd1;
  localparam logic [2:0] OP_INC   = 3'd2;
  localparam logic [2:0] OP_DEC   = 3'd3;
  localparam logic [2:0] OP_IN    = 3'd4;
  localparam logic [2:0] OP_OUT   = 3'd5;
  localparam logic [2:0] OP_OPEN  = 3'd6;
  localparam logic [2:0] OP_CLOSE = 3'd7;

  localparam logic [7:0] SEP_RESET = 8'd35;

  typedef struct packed {
    logic       hit;
    logic [2:0] op;
  } decode_t;

  // Per-item result record handed from the scan stage to the output stage.
  typedef struct packed {
    logic       r0_v;
    kind_t      r0_kind;
    logic [2:0] r0_op;
    logic [7:0] r0_lb;
    logic       r0_pop;
    logic       le_v;
    logic       t_v;
    kind_t      t_kind;
    err_t       t_err;
  } rec_ctl_t;

  function automatic decode_t decode_op(input logic [7:0] b);
    decode_t d;
    d.hit = 1'b1;
    d.op  = OP_LEFT;
    case (b)
      8'h3C: d.op = OP_LEFT;
      8'h3E: d.op = OP_RIGHT;
      8'h2B: d.op = OP_INC;
      8'h2D: d.op = OP_DEC;
      8'h2C: d.op = OP_IN;
      8'h2E: d.op = OP_OUT;
      8'h5B: d.op = OP_OPEN;
      8'h5D: d.op = OP_CLOSE;
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/bmsp_if.sv]
interface bmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       last;

  modport source (output valid, source_byte, last, input ready);
  modport sink (input valid, source_byte, last, output ready);
endinterface

interface bmsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sep_value;

  modport source (output valid, sep_value, input ready);
  modport sink (input valid, sep_value, output ready);
endinterface

interface bmsp_out_if #(parameter int POS_W = 16);
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [2:0]       opcode;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] match_position;
  logic [7:0]       label_byte;
  logic [1:0]       error_code;
  logic             final_res;

  modport source (output valid, kind, opcode, position, match_position, label_byte,
                  error_code, final_res, input ready);
  modport sink (input valid, kind, opcode, position, match_position, label_byte,
                error_code, final_res, output ready);
endinterface

[rtl/core/bmsp_stack_ram.sv]
module bmsp_stack_ram #(
  parameter int DW    = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read so a stalled record keeps its match.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/bmsp_scan.sv]
module bmsp_scan #(
  parameter int POS_W = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [7:0]               source_byte,
  input  logic                     last,
  input  logic [7:0]               separator,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [POS_W-1:0]         mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  output logic                     rec_load,
  output bmsp_pkg::rec_ctl_t       rec,
  output logic [POS_W-1:0]         r0_pos,
  output logic [POS_W-1:0]         end_pos
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [POS_W-1:0] next_position, next_position_next;
  logic [CNT_W-1:0] stack_count, stack_count_next;
  logic             in_label, in_label_next;
  logic             error_seen, error_seen_next;
  bmsp_pkg::err_t   saved_error, saved_error_next;

  bmsp_pkg::decode_t dec;
  logic              is_sep;
  logic              push;
  logic              pop;

  assign dec    = bmsp_pkg::decode_op(source_byte);
  assign is_sep = (source_byte == separator);

  assign mem_we    = fire && push;
  assign mem_waddr = stack_count[AW-1:0];
  assign mem_wdata = next_position;
  assign mem_re    = fire && pop;
  assign mem_raddr = AW'(stack_count - CNT_W'(1));
  assign rec_load  = fire && (rec.r0_v || rec.le_v || rec.t_v);
  assign r0_pos    = next_position;

  always_comb begin
    next_position_next = next_position;
    stack_count_next   = stack_count;
    in_label_next      = in_label;
    error_seen_next    = error_seen;
    saved_error_next   = saved_error;
    push               = 1'b0;
    pop                = 1'b0;
    rec                = '0;
    rec.r0_kind        = bmsp_pkg::KIND_INSTR;
    rec.t_kind         = bmsp_pkg::KIND_DONE;
    rec.t_err          = bmsp_pkg::ERR_UNMATCHED;
    end_pos            = '0;

    if (!error_seen) begin
      if (in_label) begin
        rec.r0_v = 1'b1;
        if (is_sep) begin
          in_label_next = 1'b0;
          rec.r0_kind   = bmsp_pkg::KIND_LABEL_END;
        end else begin
          rec.r0_kind = bmsp_pkg::KIND_LABEL_BYTE;
          rec.r0_lb   = source_byte;
        end
      end else if (is_sep) begin
        in_label_next = 1'b1;
      end else if (dec.hit) begin
        if (next_position == {POS_W{1'b1}}) begin
          error_seen_next  = 1'b1;
          saved_error_next = bmsp_pkg::ERR_LONG;
        end else if (dec.op == bmsp_pkg::OP_OPEN &&
                     stack_count == CNT_W'(DEPTH)) begin
          error_seen_next  = 1'b1;
          saved_error_next = bmsp_pkg::ERR_DEPTH;
        end else if (dec.op == bmsp_pkg::OP_CLOSE && stack_count == '0) begin
          error_seen_next  = 1'b1;
          saved_error_next = bmsp_pkg::ERR_UNMATCHED;
        end else begin
          rec.r0_v           = 1'b1;
          rec.r0_op          = dec.op;
          next_position_next = next_position + POS_W'(1);
          if (dec.op == bmsp_pkg::OP_OPEN) begin
            push             = 1'b1;
            stack_count_next = stack_count + CNT_W'(1);
          end else if (dec.op == bmsp_pkg::OP_CLOSE) begin
            pop              = 1'b1;
            rec.r0_pop       = 1'b1;
            stack_count_next = stack_count - CNT_W'(1);
          end
        end
      end
    end

    if (last) begin
      end_pos = next_position_next;
      rec.t_v = 1'b1;
      if (error_seen_next) begin
        rec.r0_v   = 1'b0;
        rec.t_kind = bmsp_pkg::KIND_ERROR;
        rec.t_err  = saved_error_next;
      end else begin
        rec.le_v = in_label_next;
        if (stack_count_next != '0) begin
          rec.t_kind = bmsp_pkg::KIND_ERROR;
          rec.t_err  = bmsp_pkg::ERR_UNCLOSED;
        end
      end
      // Start the next program from a clean state.
      next_position_next = '0;
      stack_count_next   = '0;
      in_label_next      = 1'b0;
      error_seen_next    = 1'b0;
      saved_error_next   = bmsp_pkg::ERR_UNMATCHED;
    end else if (error_seen_next) begin
      rec.r0_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_position <= '0;
      stack_count   <= '0;
      in_label      <= 1'b0;
      error_seen    <= 1'b0;
      saved_error   <= bmsp_pkg::ERR_UNMATCHED;
    end else if (fire) begin
      next_position <= next_position_next;
      stack_count   <= stack_count_next;
      in_label      <= in_label_next;
      error_seen    <= error_seen_next;
      saved_error   <= saved_error_next;
    end
  end

endmodule

[rtl/core/bmsp_drain.sv]
module bmsp_drain #(
  parameter int POS_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_load,
  input  bmsp_pkg::rec_ctl_t rec_in,
  input  logic [POS_W-1:0]   r0_pos_in,
  input  logic [POS_W-1:0]   end_pos_in,
  input  logic [POS_W-1:0]   match_data,
  output logic               take_ok,
  bmsp_out_if.source         res
);

  logic [2:0]         pend, pend_next;
  bmsp_pkg::rec_ctl_t rec;
  logic [POS_W-1:0]   r0_pos;
  logic [POS_W-1:0]   end_pos;
  logic               move;

  assign move    = (pend != '0) && (!res.valid || res.ready);
  assign take_ok = (pend_next == '0) || (pend == '0);

  // Retire the lowest pending result on each move.
  always_comb begin
    pend_next = pend;
    if (move) begin
      if (pend[0]) begin
        pend_next[0] = 1'b0;
      end else if (pend[1]) begin
        pend_next[1] = 1'b0;
      end else begin
        pend_next[2] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (rec_load) begin
      pend <= {rec_in.t_v, rec_in.le_v, rec_in.r0_v};
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec     <= rec_in;
      r0_pos  <= r0_pos_in;
      end_pos <= end_pos_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (move) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res.final_res      <= (pend_next == '0);
      res.opcode         <= '0;
      res.position       <= '0;
      res.match_position <= '0;
      res.label_byte     <= '0;
      res.error_code     <= '0;
      if (pend[0]) begin
        res.kind     <= rec.r0_kind;
        res.opcode   <= rec.r0_op;
        res.position <= r0_pos;
        res.label_byte <= rec.r0_lb;
        if (rec.r0_pop) begin
          res.match_position <= match_data;
        end
      end else if (pend[1]) begin
        res.kind     <= bmsp_pkg::KIND_LABEL_END;
        res.position <= end_pos;
      end else begin
        res.kind <= rec.t_kind;
        if (rec.t_kind == bmsp_pkg::KIND_ERROR) begin
          res.error_code <= rec.t_err;
        end else begin
          res.position <= end_pos;
        end
      end
    end
  end

endmodule

[rtl/core/bracket_matching_source_parser_unit.sv]
// Channel  Dir  Payload                                         Handshake
// src      in   source_byte[7:0], last                          valid/ready
// res      out  kind, opcode, position, match_position,         valid/ready
//               label_byte, error_code, final_res
// cfg      in   sep_value[7:0]                                  valid/ready, always ready
//
// One source byte per cycle unless the res channel stalls; each byte does at most one stack read or write.
// A byte yields at most one result, except the last byte, which yields up to three,
// so after the last byte the input is held until those results have drained.
// Each result is registered in the drain's record register and then in the output register.
// rst is synchronous: clears parser state and the separator (to '#'); stack contents
// are not cleared and need no clearing pass.
module bracket_matching_source_parser_unit #(
  parameter int POSITION_BITS = 16,
  parameter int STACK_DEPTH   = 64
) (
  input  logic        clk,
  input  logic        rst,
  bmsp_in_if.sink     src,
  bmsp_cfg_if.sink    cfg,
  bmsp_out_if.source  res
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]               separator;
  logic                     fire;
  logic                     take_ok;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [POSITION_BITS-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [POSITION_BITS-1:0] mem_rdata;
  logic                     rec_load;
  bmsp_pkg::rec_ctl_t       rec;
  logic [POSITION_BITS-1:0] r0_pos;
  logic [POSITION_BITS-1:0] end_pos;

  assign cfg.ready = 1'b1;
  assign src.ready = take_ok;
  assign fire      = src.valid && take_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= bmsp_pkg::SEP_RESET;
    end else if (cfg.valid) begin
      separator <= cfg.sep_value;
    end
  end

  bmsp_scan #(
    .POS_W (POSITION_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .source_byte (src.source_byte),
    .last        (src.last),
    .separator   (separator),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .rec_load    (rec_load),
    .rec         (rec),
    .r0_pos      (r0_pos),
    .end_pos     (end_pos)
  );

  bmsp_stack_ram #(
    .DW    (POSITION_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmsp_drain #(
    .POS_W (POSITION_BITS)
  ) u_drain (
    .clk        (clk),
    .rst        (rst),
    .rec_load   (rec_load),
    .rec_in     (rec),
    .r0_pos_in  (r0_pos),
    .end_pos_in (end_pos),
    .match_data (mem_rdata),
    .take_ok    (take_ok),
    .res        (res)
  );

`ifndef SYNTHESIS
  a_error_is_final: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == bmsp_pkg::KIND_ERROR |-> res.final_res)
    else $error("error result not marked final");

  a_done_is_final: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == bmsp_pkg::KIND_DONE |-> res.final_res)
    else $error("done result not marked final");

  a_match_only_on_instr: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind != bmsp_pkg::KIND_INSTR |-> res.match_position == '0)
    else $error("match position set on non-instruction result");

  a_no_mem_collision: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("stack push and pop in one cycle");
`endif

endmodule
